[sv/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Shared command and status types for the sorted set search/insert block.
// ----------------------------------------------------------------------------
package sss_pkg;

	typedef struct packed {
		logic load;
		logic probe_rd;
		logic probe_upd;
		logic shift_step;
		logic insert;
		logic out_load;
	} sss_cmd_t;

	typedef struct packed {
		logic search_done;
		logic found;
		logic full;
		logic shift_done;
		logic out_free;
	} sss_status_t;

endpackage

[sv/sss_dpath.sv]
// ----------------------------------------------------------------------------
// sss_dpath
// Datapath: value table memory, search bounds, shift pointer, count and the
// result register.
// ----------------------------------------------------------------------------
module sss_dpath import sss_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32,
	parameter int AW          = $clog2(TABLE_DEPTH),
	parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sss_cmd_t               cmd,
	output sss_status_t            status,
	input  logic [VALUE_WIDTH-1:0] key_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   was_found,
	output logic [CW-1:0]          position,
	output logic                   full_reject,
	output logic [CW-1:0]          entry_count
);

	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic signed [VALUE_WIDTH-1:0] rdata_q;
	logic [CW-1:0]                 lo_q, hi_q, ptr_q, count_q;
	logic                          found_q;
	logic                          ins_q;
	logic                          wr_pend_s1;
	logic [AW-1:0]                 waddr_s1;
	logic [CW-1:0]                 mid;
	logic [CW-1:0]                 ptr_dec;
	logic                          rd_en;
	logic [AW-1:0]                 raddr;
	logic                          we;
	logic [AW-1:0]                 waddr;
	logic signed [VALUE_WIDTH-1:0] wdata;
	logic                          shift_rd;
	logic                          out_valid_q;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign ptr_dec  = ptr_q - ONE_C;
	assign shift_rd = cmd.shift_step && (ptr_q != lo_q);

	always_comb begin
		rd_en = cmd.probe_rd || shift_rd;
		raddr = cmd.probe_rd ? mid[AW-1:0] : ptr_dec[AW-1:0];
		we    = cmd.insert || wr_pend_s1;
		waddr = cmd.insert ? lo_q[AW-1:0] : waddr_s1;
		wdata = cmd.insert ? key_q : rdata_q;
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_value;
			lo_q  <= '0;
			hi_q  <= count_q;
			ptr_q <= count_q;
		end else if (cmd.probe_upd) begin
			if (rdata_q < key_q) begin
				lo_q <= mid + ONE_C;
			end else begin
				hi_q <= mid;
			end
		end else if (shift_rd) begin
			ptr_q <= ptr_dec;
		end
		if (shift_rd) begin
			waddr_s1 <= ptr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			found_q     <= 1'b0;
			ins_q       <= 1'b0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_pend_s1 <= shift_rd;
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.probe_upd && (rdata_q == key_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.load) begin
				ins_q <= 1'b0;
			end else if (cmd.insert) begin
				ins_q <= 1'b1;
			end
			if (cmd.insert) begin
				count_q <= count_q + ONE_C;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			was_found   <= found_q;
			full_reject <= !found_q && !ins_q;
			position    <= (!found_q && !ins_q) ? '0 : lo_q + ONE_C;
			entry_count <= count_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.search_done = (lo_q >= hi_q);
		status.found       = found_q;
		status.full        = (count_q == DEPTH_C);
		status.shift_done  = (ptr_q == lo_q);
		status.out_free    = !out_valid_q || out_ready;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("count above table depth");
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (count_q != DEPTH_C) && !found_q) else $error("insert into full table");
	a_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> !cmd.insert) else $error("shift write collides with insert");
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_rd |-> (ptr_q > lo_q) && (ptr_q <= count_q)) else $error("shift pointer out of range");
`endif

endmodule

[sv/sss_ctrl.sv]
// ----------------------------------------------------------------------------
// sss_ctrl
// Controller: sequences search probes, the shift-up pass, insert and result.
// ----------------------------------------------------------------------------
module sss_ctrl import sss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sss_status_t status,
	output sss_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_PROBE_RD  = 7'b0000010,
		ST_PROBE_CMP = 7'b0000100,
		ST_SHIFT     = 7'b0001000,
		ST_INSERT    = 7'b0010000,
		ST_RESULT    = 7'b0100000,
		ST_SPARE     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PROBE_RD;
				end
			end
			ST_PROBE_RD: begin
				if (status.search_done) begin
					if (status.found || status.full) begin
						state_d = ST_RESULT;
					end else begin
						state_d = ST_SHIFT;
					end
				end else begin
					cmd.probe_rd = 1'b1;
					state_d      = ST_PROBE_CMP;
				end
			end
			ST_PROBE_CMP: begin
				cmd.probe_upd = 1'b1;
				state_d       = ST_PROBE_RD;
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (status.shift_done) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one command");
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_rd |=> cmd.probe_upd) else $error("probe read without compare");
`endif

endmodule

[sv/sorted_set_search_insert.sv]
// ----------------------------------------------------------------------------
// sorted_set_search_insert
// Sorted set of distinct signed values with binary search and ordered insert.
// ----------------------------------------------------------------------------
// Each word on the input channel is looked up in an ascending table held in a
// single-port-write, registered-read memory; the table is empty after reset
// and needs no clearing pass. A present value returns was_found and its
// 1-based position; an absent value is inserted in order and its 1-based
// position returned; an absent value on a full table returns full_reject with
// position 0 and leaves the table alone. Each search probe is a memory read,
// then a compare and bound update. An insert first runs the shift pass, which
// moves each larger entry up one place and goes through the memory one entry
// a cycle, and then writes the new value in its place.
// The result register lets the next word be accepted while a result waits.
module sorted_set_search_insert import sss_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [VALUE_WIDTH-1:0]             key_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               was_found,
	output logic [$clog2(TABLE_DEPTH + 1)-1:0] position,
	output logic                               full_reject,
	output logic [$clog2(TABLE_DEPTH + 1)-1:0] entry_count
);

	sss_cmd_t    cmd;
	sss_status_t status;

	sss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sss_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.key_value   (key_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.was_found   (was_found),
		.position    (position),
		.full_reject (full_reject),
		.entry_count (entry_count)
	);

endmodule

[sim/tb_sorted_set_search_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_set_search_insert
// Self-checking bench for the sorted set search/insert block. Keys are sent
// on the input channel and each result word is checked against a queue-based
// copy of the sorted set. The set grows from empty through directed extremes
// and random keys, is filled to capacity in ascending order, and is then hit
// with found and rejected lookups under several idling mixes and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_set_search_insert;

	localparam int TABLE_DEPTH  = 1024;
	localparam int VALUE_WIDTH  = 32;
	localparam int POS_W        = $clog2(TABLE_DEPTH + 1);
	localparam int LIMIT_CYCLES = 4000000;
	localparam int HOLD_CYCLES  = 600;
	localparam int TAIL_CYCLES  = 1100;
	localparam int MAX_REPORTS  = 10;

	localparam int SRC_IDLE_MODES [4] = '{0, 66, 0, 19};
	localparam int RCV_STALL_MODES[4] = '{0, 0, 66, 19};

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
		logic             reject;
		logic [POS_W-1:0] count;
	} lookup_result_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic signed [VALUE_WIDTH-1:0] key_value   = '0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic                          was_found;
	logic [POS_W-1:0]              position;
	logic                          full_reject;
	logic [POS_W-1:0]              entry_count;

	logic signed [VALUE_WIDTH-1:0] sorted_vals[$];
	lookup_result_t                pending_lookups[$];

	int   src_idle_pct   = 0;
	int   rcv_stall_pct  = 0;
	int   mismatch_count = 0;
	int   cycle_count    = 0;
	logic hold_off       = 1'b0;
	event hold_start;

	sorted_set_search_insert #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_value  (key_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.was_found  (was_found),
		.position   (position),
		.full_reject(full_reject),
		.entry_count(entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_sorted_set_search_insert failed");
			$finish;
		end
	end

	// long output hold-off, counted here so the sender keeps pushing meanwhile
	always begin
		@(hold_start);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// lookup in the sorted set, insert if absent and there is room
	function automatic lookup_result_t lookup_or_insert(input logic signed [VALUE_WIDTH-1:0] key);
		int             lo;
		int             hi;
		int             mid;
		lookup_result_t res;
		lo  = 0;
		hi  = sorted_vals.size();
		res = '0;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (sorted_vals[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		if (lo < sorted_vals.size() && sorted_vals[lo] == key) begin
			res.found = 1'b1;
			res.pos   = POS_W'(lo + 1);
		end else if (sorted_vals.size() >= TABLE_DEPTH) begin
			res.reject = 1'b1;
		end else begin
			sorted_vals.insert(lo, key);
			res.pos = POS_W'(lo + 1);
		end
		res.count = POS_W'(sorted_vals.size());
		return res;
	endfunction

	task automatic send_key(input logic signed [VALUE_WIDTH-1:0] key);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		key_value <= key;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_lookups.push_back(lookup_or_insert(key));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		lookup_result_t want;
		if (out_valid && out_ready) begin
			if (pending_lookups.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected word: found=%0d pos=%0d reject=%0d count=%0d",
						was_found, position, full_reject, entry_count);
			end else begin
				want = pending_lookups.pop_front();
				if (was_found !== want.found || position !== want.pos ||
						full_reject !== want.reject || entry_count !== want.count) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: exp found=%0d pos=%0d reject=%0d count=%0d, got found=%0d pos=%0d reject=%0d count=%0d",
							want.found, want.pos, want.reject, want.count,
							was_found, position, full_reject, entry_count);
				end
			end
		end
		out_ready <= !hold_off && ($urandom_range(99) >= rcv_stall_pct);
	end

	task automatic test_empty_and_extremes();
		src_idle_pct  = 0;
		rcv_stall_pct = 0;
		send_key(32'sd0);
		send_key(32'sd0);
		send_key(32'sh8000_0000);
		send_key(32'sh7FFF_FFFF);
		send_key(-32'sd1);
		send_key(32'sd1);
		send_key(32'sh8000_0000);
		send_key(32'sh7FFF_FFFF);
		send_key(32'sh8000_0001);
		send_key(32'sh7FFF_FFFE);
		send_key(32'sh5555_5555);
		send_key(32'shAAAA_AAAA);
		send_key(-32'sd1);
		send_key(32'sh5555_5555);
		wait_all_results();
	endtask

	task automatic test_random_growth();
		logic signed [VALUE_WIDTH-1:0] key;
		int                            sel;
		for (int m = 0; m < 4; m++) begin
			src_idle_pct  = SRC_IDLE_MODES[m];
			rcv_stall_pct = RCV_STALL_MODES[m];
			for (int n = 0; n < 40; n++) begin
				sel = $urandom_range(99);
				if (sel < 40) begin
					key = $urandom_range(127) - 64;
				end else if (sel < 60) begin
					key = sorted_vals[$urandom_range(sorted_vals.size() - 1)];
				end else if (sel < 70) begin
					key = 32'sh8000_0000 + $urandom_range(15);
				end else if (sel < 75) begin
					key = 32'sh7FFF_FFFF - $urandom_range(15);
				end else begin
					key = $urandom;
				end
				send_key(key);
			end
			wait_all_results();
		end
	endtask

	// ascending keys just below the top entries keep the shift pass short
	task automatic test_fill_to_capacity();
		logic signed [VALUE_WIDTH-1:0] key;
		src_idle_pct  = 0;
		rcv_stall_pct = 19;
		key           = 32'sh7FFF_0000;
		while (sorted_vals.size() < TABLE_DEPTH) begin
			send_key(key);
			key++;
		end
		wait_all_results();
	endtask

	task automatic test_full_table();
		logic signed [VALUE_WIDTH-1:0] key;
		src_idle_pct  = 0;
		rcv_stall_pct = 0;
		send_key(sorted_vals[0]);
		send_key(sorted_vals[TABLE_DEPTH - 1]);
		send_key(32'sh8000_0000);
		send_key(32'sh7FFF_FFFF);
		send_key(sorted_vals[TABLE_DEPTH / 2]);
		send_key($urandom);
		send_key($urandom);
		for (int m = 0; m < 4; m++) begin
			src_idle_pct  = SRC_IDLE_MODES[m];
			rcv_stall_pct = RCV_STALL_MODES[m];
			for (int n = 0; n < 15; n++) begin
				if ($urandom_range(99) < 40) begin
					key = sorted_vals[$urandom_range(TABLE_DEPTH - 1)];
				end else begin
					key = $urandom;
				end
				send_key(key);
			end
			wait_all_results();
		end
	endtask

	task automatic test_output_backpressure();
		src_idle_pct  = 0;
		rcv_stall_pct = 0;
		-> hold_start;
		for (int n = 0; n < 20; n++) begin
			if (n % 3 == 0) begin
				send_key(sorted_vals[$urandom_range(TABLE_DEPTH - 1)]);
			end else begin
				send_key($urandom);
			end
		end
		wait_all_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		test_random_growth();
		test_fill_to_capacity();
		test_full_table();
		test_output_backpressure();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_lookups.size() == 0) begin
			$display("tb_sorted_set_search_insert passed");
		end else begin
			$display("tb_sorted_set_search_insert failed");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/sss_pkg.sv
sv/sss_dpath.sv
sv/sss_ctrl.sv
sv/sorted_set_search_insert.sv
sim/tb_sorted_set_search_insert.sv
